// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file uyvy_chk.sv
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, reset included
`define CHK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

// property checked only outside reset
`define CHK_ACTIVE(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/uyvy_pkg.sv =====
// types and constants for the uyvy pixel pair to rgb converter
// no dependencies
`default_nettype none

package uyvy_pkg;

   // q12 colour matrix coefficients (bt.601 studio range)
   localparam int QBits = 12;
   localparam logic signed [14:0] COEF_Y  = 15'sd4768;
   localparam logic signed [14:0] COEF_RV = 15'sd6537;
   localparam logic signed [14:0] COEF_GV = 15'sd3330;
   localparam logic signed [14:0] COEF_GU = 15'sd1602;
   localparam logic signed [14:0] COEF_BU = 15'sd8266;

   // luma black level
   localparam logic [8:0] LUMA_BLACK = 9'd16;

   // input word: one packed uyvy group
   typedef struct packed {
      logic [7:0] chroma_u;
      logic [7:0] luma_first;
      logic [7:0] chroma_v;
      logic [7:0] luma_second;
   } req_word_type;

   // output word: two rgb888 pixels
   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/uyvy_to_rgb_pixel_pair.sv =====
// uyvy 4:2:2 pixel pair to two rgb888 pixels, four-stage pipeline
// depends on uyvy_pkg
`default_nettype none

// Converts one UYVY word (U, Y0, V, Y1) per cycle while not stalled into two
// RGB888 pixels sharing the chroma pair, using BT.601 studio-range Q12
// arithmetic with clamping to 0..255. A word enters every cycle unless
// req_stall is high and passes four register stages (offset removal, constant
// multiplies, channel sums, clamp into the output register); the output
// register's valid bit drives rsp_valid. Every stage holds its own valid bit
// and only stops when the stage ahead is full and cannot move, so bubbles are
// squeezed out and a stall on the result side reaches req_stall only once all
// four stages are occupied.
module uyvy_to_rgb_pixel_pair (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  uyvy_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output uyvy_pkg::rsp_word_type  rsp_word
);

   // clamp a q12 sum to an 8-bit channel, truncating toward zero
   function automatic logic [7:0] clamp_channel(input logic signed [22:0] sum);
      logic [10:0] q;
      begin
         q = sum[22:12];
         if (sum[22] || sum == 23'sd0) begin
            clamp_channel = 8'd0;
         end else if (q[10:8] != 3'd0) begin
            clamp_channel = 8'hff;
         end else begin
            clamp_channel = q[7:0];
         end
      end
   endfunction

   // stage valid bits and advance conditions
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic s1_vld_in, s2_vld_in, s3_vld_in, s4_vld_in;
   logic s1_adv, s2_adv, s3_adv, s4_adv;

   assign s4_adv = !s4_vld_ff || !rsp_stall;
   assign s3_adv = !s3_vld_ff || s4_adv;
   assign s2_adv = !s2_vld_ff || s3_adv;
   assign s1_adv = !s1_vld_ff || s2_adv;

   assign req_stall = !s1_adv;

   assign s1_vld_in = s1_adv ? req_valid : s1_vld_ff;
   assign s2_vld_in = s2_adv ? s1_vld_ff : s2_vld_ff;
   assign s3_vld_in = s3_adv ? s2_vld_ff : s3_vld_ff;
   assign s4_vld_in = s4_adv ? s3_vld_ff : s4_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s4_vld_in;
      end
   end

   // stage 1: remove luma black level and chroma midpoint
   logic signed [8:0] y0_off_ff, y1_off_ff, y0_off_in, y1_off_in;
   logic signed [7:0] u_off_ff, v_off_ff, u_off_in, v_off_in;

   assign y0_off_in = $signed({1'b0, req_word.luma_first} - uyvy_pkg::LUMA_BLACK);
   assign y1_off_in = $signed({1'b0, req_word.luma_second} - uyvy_pkg::LUMA_BLACK);
   assign u_off_in  = $signed({~req_word.chroma_u[7], req_word.chroma_u[6:0]});
   assign v_off_in  = $signed({~req_word.chroma_v[7], req_word.chroma_v[6:0]});

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         y0_off_ff <= y0_off_in;
         y1_off_ff <= y1_off_in;
         u_off_ff  <= u_off_in;
         v_off_ff  <= v_off_in;
      end
   end

   // stage 2: constant multiplies
   logic signed [23:0] yt0_full, yt1_full, rv_full, gv_full, gu_full, bu_full;
   logic signed [21:0] yt0_ff, yt1_ff, rv_ff, gv_ff, gu_ff, bu_ff;

   assign yt0_full = y0_off_ff * uyvy_pkg::COEF_Y;
   assign yt1_full = y1_off_ff * uyvy_pkg::COEF_Y;
   assign rv_full  = v_off_ff * uyvy_pkg::COEF_RV;
   assign gv_full  = v_off_ff * uyvy_pkg::COEF_GV;
   assign gu_full  = u_off_ff * uyvy_pkg::COEF_GU;
   assign bu_full  = u_off_ff * uyvy_pkg::COEF_BU;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         yt0_ff <= yt0_full[21:0];
         yt1_ff <= yt1_full[21:0];
         rv_ff  <= rv_full[21:0];
         gv_ff  <= gv_full[21:0];
         gu_ff  <= gu_full[21:0];
         bu_ff  <= bu_full[21:0];
      end
   end

   // stage 3: channel sums at full precision
   logic signed [23:0] r0_sum, g0_sum, b0_sum, r1_sum, g1_sum, b1_sum;
   logic signed [22:0] r0_ff, g0_ff, b0_ff, r1_ff, g1_ff, b1_ff;

   assign r0_sum = yt0_ff + rv_ff;
   assign g0_sum = yt0_ff - gv_ff - gu_ff;
   assign b0_sum = yt0_ff + bu_ff;
   assign r1_sum = yt1_ff + rv_ff;
   assign g1_sum = yt1_ff - gv_ff - gu_ff;
   assign b1_sum = yt1_ff + bu_ff;

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         r0_ff <= r0_sum[22:0];
         g0_ff <= g0_sum[22:0];
         b0_ff <= b0_sum[22:0];
         r1_ff <= r1_sum[22:0];
         g1_ff <= g1_sum[22:0];
         b1_ff <= b1_sum[22:0];
      end
   end

   // stage 4: clamp into the output register
   uyvy_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   always_comb begin
      rsp_word_in.red_first    = clamp_channel(r0_ff);
      rsp_word_in.green_first  = clamp_channel(g0_ff);
      rsp_word_in.blue_first   = clamp_channel(b0_ff);
      rsp_word_in.red_second   = clamp_channel(r1_ff);
      rsp_word_in.green_second = clamp_channel(g1_ff);
      rsp_word_in.blue_second  = clamp_channel(b1_ff);
   end

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = s4_vld_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== rtl/uyvy_chk.sv =====
// port-level checker for the uyvy to rgb converter, bound to the top level
// depends on uyvy_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module uyvy_chk (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input uyvy_pkg::req_word_type req_word,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input uyvy_pkg::rsp_word_type rsp_word
);

   // a held result word keeps its value
   `CHK_ACTIVE(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))

   // pipeline comes out of reset empty
   `CHK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // back-pressure only when the output is full and held
   `CHK_ALWAYS(a_stall_cause, clock, req_stall |-> rsp_valid && rsp_stall)

   // an input word seen while the output moves freely is never refused
   `CHK_ACTIVE(a_flow, clock, reset, !rsp_stall |-> !req_stall)

endmodule

bind uyvy_to_rgb_pixel_pair uyvy_chk u_uyvy_chk (.*);

`default_nettype wire
